/* hdl/vnf_pkg.sv */
// Shared types, hash constants and fixed-point constants of the value noise block.
package vnf_pkg;

    localparam int COORD_W = 64;
    localparam int SUM_W   = 28;
    localparam int QUOT_W  = 17;
    localparam int OUT_W   = 18;
    localparam int OCT_STAGES = 9;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]   t_sum;

    localparam logic [31:0] HASH_MUL_X = 32'h9E3779B9;
    localparam logic [31:0] HASH_MUL_Y = 32'h85EBCA6B;
    localparam logic [31:0] HASH_MUL_K = 32'hC2B2AE35;
    localparam logic [31:0] HASH_MUL_A = 32'h7FEB352D;
    localparam logic [31:0] HASH_MUL_B = 32'h846CA68B;
    localparam logic [31:0] OCT_KEY_STEP = 32'd1013;

    localparam t_coord COORD_SCALE_FRAC = 64'sd1966;
    localparam t_coord COORD_X_OFS = 64'sd1122632;
    localparam t_coord COORD_Y_OFS = -64'sd767427;

    localparam logic [1:0] REG_SEED = 2'd0;

endpackage

/* hdl/vnf_octave.sv */
// One octave of lattice value noise as a nine-stage pipeline.
module vnf_octave import vnf_pkg::*; #(
    parameter int OCT_IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_seed,
    input  logic        i_valid,
    input  t_coord      i_x,
    input  t_coord      i_y,
    input  t_sum        i_sum,
    output logic        o_valid,
    output t_coord      o_x,
    output t_coord      o_y,
    output t_sum        o_sum
);

    logic [OCT_STAGES-1:0] r_vld;
    logic [31:0] r_kmix;

    logic [31:0] r1_px, r1_py, r1_ttx, r1_tty;
    logic [15:0] r1_tx, r1_ty;
    t_coord      r1_xm, r1_ym, r1_x, r1_y;
    t_sum        r1_sum;

    logic [31:0] r2_h [0:3];
    logic [31:0] r3_h [0:3];
    logic [31:0] r4_h [0:3];
    logic [23:0] r5_c [0:3];
    logic [16:0] r2_sx, r2_sy, r3_sx, r3_sy, r4_sx, r4_sy, r5_sx, r5_sy, r6_sy, r7_sy;
    t_coord      r2_x, r2_y, r3_x, r3_y, r4_x, r4_y, r5_x, r5_y, r6_x, r6_y;
    t_coord      r7_x, r7_y, r8_x, r8_y, r9_x, r9_y;
    t_sum        r2_sum, r3_sum, r4_sum, r5_sum, r6_sum, r7_sum, r8_sum, r9_sum;

    logic signed [42:0] r6_pa, r6_pb;
    logic [23:0]        r6_c0, r6_c2;
    logic signed [25:0] r7_ra, r7_rb, r8_ra;
    logic signed [43:0] r8_pr;

    logic [31:0] n_h [0:3];
    logic [49:0] n_smx, n_smy;
    logic signed [24:0] n_da, n_db;
    logic signed [25:0] n_d, n_v;
    logic signed [27:0] n_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[OCT_STAGES-2:0], i_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_h[i] = (((i % 2) == 1) ? r1_px + HASH_MUL_X : r1_px)
                   ^ ((i >= 2) ? r1_py + HASH_MUL_Y : r1_py)
                   ^ r_kmix;
        end
        n_smx = 50'(r1_ttx) * 50'(18'd196608 - 18'({r1_tx, 1'b0}));
        n_smy = 50'(r1_tty) * 50'(18'd196608 - 18'({r1_ty, 1'b0}));
        n_da = $signed({1'b0, r5_c[1]}) - $signed({1'b0, r5_c[0]});
        n_db = $signed({1'b0, r5_c[3]}) - $signed({1'b0, r5_c[2]});
        n_d = r7_rb - r7_ra;
        n_v = r8_ra + 26'(r8_pr >>> 16);
        n_n = (28'(n_v) <<< 1) - 28'sd16777216;
    end

    always_ff @(posedge i_clk) begin
        r_kmix <= (i_seed + 32'(OCT_IDX * 1013)) * HASH_MUL_K;

        r1_px  <= i_x[47:16] * HASH_MUL_X;
        r1_py  <= i_y[47:16] * HASH_MUL_Y;
        r1_ttx <= 32'(i_x[15:0]) * 32'(i_x[15:0]);
        r1_tty <= 32'(i_y[15:0]) * 32'(i_y[15:0]);
        r1_tx  <= i_x[15:0];
        r1_ty  <= i_y[15:0];
        r1_xm  <= i_x * COORD_SCALE_FRAC;
        r1_ym  <= i_y * COORD_SCALE_FRAC;
        r1_x   <= i_x;
        r1_y   <= i_y;
        r1_sum <= i_sum;

        for (int i = 0; i < 4; i++) begin
            r2_h[i] <= n_h[i] ^ (n_h[i] >> 16);
            r3_h[i] <= r2_h[i] * HASH_MUL_A;
            r4_h[i] <= (r3_h[i] ^ (r3_h[i] >> 15)) * HASH_MUL_B;
            r5_c[i] <= r4_h[i][23:0] ^ 24'(r4_h[i] >> 16);
        end
        r2_sx  <= n_smx[48:32];
        r2_sy  <= n_smy[48:32];
        r2_x   <= (r1_x <<< 1) + (r1_xm >>> 16) + COORD_X_OFS;
        r2_y   <= (r1_y <<< 1) + (r1_ym >>> 16) + COORD_Y_OFS;
        r2_sum <= r1_sum;

        r3_sx <= r2_sx;  r3_sy <= r2_sy;  r3_x <= r2_x;  r3_y <= r2_y;  r3_sum <= r2_sum;
        r4_sx <= r3_sx;  r4_sy <= r3_sy;  r4_x <= r3_x;  r4_y <= r3_y;  r4_sum <= r3_sum;
        r5_sx <= r4_sx;  r5_sy <= r4_sy;  r5_x <= r4_x;  r5_y <= r4_y;  r5_sum <= r4_sum;

        r6_pa  <= 43'(n_da) * 43'($signed({1'b0, r5_sx}));
        r6_pb  <= 43'(n_db) * 43'($signed({1'b0, r5_sx}));
        r6_c0  <= r5_c[0];
        r6_c2  <= r5_c[2];
        r6_sy  <= r5_sy;  r6_x <= r5_x;  r6_y <= r5_y;  r6_sum <= r5_sum;

        r7_ra  <= $signed({2'b00, r6_c0}) + 26'(r6_pa >>> 16);
        r7_rb  <= $signed({2'b00, r6_c2}) + 26'(r6_pb >>> 16);
        r7_sy  <= r6_sy;  r7_x <= r6_x;  r7_y <= r6_y;  r7_sum <= r6_sum;

        r8_pr  <= 44'(n_d) * 44'($signed({1'b0, r7_sy}));
        r8_ra  <= r7_ra;
        r8_x   <= r7_x;  r8_y <= r7_y;  r8_sum <= r7_sum;

        r9_sum <= r8_sum + (n_n >>> OCT_IDX);
        r9_x   <= r8_x;
        r9_y   <= r8_y;
    end

    assign o_valid = r_vld[OCT_STAGES-1];
    assign o_x     = r9_x;
    assign o_y     = r9_y;
    assign o_sum   = r9_sum;

endmodule

/* hdl/vnf_div.sv */
// Pipelined rounding division of the octave sum by the total octave weight.
module vnf_div import vnf_pkg::*; #(
    parameter int OCTAVES = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_sum                    i_sum,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_value
);

    // The weight is (2^OCTAVES - 1) * 2^(25 - OCTAVES), so the division is a shift
    // followed by a reciprocal multiplication that is exact for dividends below 2^24.
    localparam int NUM_W   = 44;
    localparam int SHIFT   = 25 - OCTAVES;
    localparam int DIV_W   = 25;
    localparam int RECIP_W = 33;
    localparam int PROD_W  = DIV_W + RECIP_W;
    localparam logic [NUM_W-1:0] WEIGHT =
        NUM_W'((64'd1 << 25) - (64'd1 << SHIFT));
    localparam logic [63:0] DIVISOR = (64'd1 << OCTAVES) - 64'd1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << 32) + DIVISOR - 64'd1) / DIVISOR);

    logic [2:0]              r_vld;
    logic [DIV_W-1:0]        r_num;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_neg1, r_neg2;
    logic signed [OUT_W-1:0] r_out;
    logic [SUM_W-1:0]        n_mag;
    logic [NUM_W-1:0]        n_num;
    logic [QUOT_W-1:0]       n_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign n_mag  = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign n_num  = (NUM_W'(n_mag) << 16) + (WEIGHT >> 1);
    assign n_quot = r_prod[32 +: QUOT_W];

    always_ff @(posedge i_clk) begin
        r_num  <= DIV_W'(n_num >> SHIFT);
        r_neg1 <= i_sum[SUM_W-1];

        r_prod <= PROD_W'(r_num) * PROD_W'(RECIP);
        r_neg2 <= r_neg1;

        r_out  <= r_neg2 ? -$signed(OUT_W'(n_quot)) : $signed(OUT_W'(n_quot));
    end

    assign o_valid = r_vld[2];
    assign o_value = r_out;

endmodule

/* hdl/value_noise_fbm_top.sv */
// Top level of the fractal value noise block with its register port.
// Usage: write the 32-bit seed over the APB-style port at byte address 0
// (reads return it) while no sample is in flight. A sample is a transfer of
// i_x_coord and i_y_coord (signed Q24.16), taken at a clock edge with start
// high; busy never rises, so one sample can enter in every cycle.
// Each octave is a nine-stage pipeline and the octaves are chained, so the
// octave chain dominates the latency; a three-stage divider by the constant total
// weight follows (a shift, then a reciprocal multiplication). Throughput is
// one sample per cycle.
// The result appears on o_noise_value (signed Q2.16) for exactly one cycle,
// marked by o_noise_valid; the receiver takes it in that cycle.
// Reset clears the seed and all valid bits, dropping samples in flight.
module value_noise_fbm_top import vnf_pkg::*; #(
    parameter int OCTAVES = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [1:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [39:0]      i_x_coord,
    input  logic signed [39:0]      i_y_coord,
    output logic                    o_noise_valid,
    output logic signed [OUT_W-1:0] o_noise_value
);

    localparam int LATENCY = 1 + OCT_STAGES * OCTAVES + 3;

    logic [31:0] r_seed;
    logic        r_in_vld;
    t_coord      r_in_x, r_in_y;

    logic   oct_vld [0:OCTAVES];
    t_coord oct_x   [0:OCTAVES];
    t_coord oct_y   [0:OCTAVES];
    t_sum   oct_sum [0:OCTAVES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= '0;
            r_in_vld <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_SEED) begin
                r_seed <= pwdata;
            end
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_x <= COORD_W'(i_x_coord);
        r_in_y <= COORD_W'(i_y_coord);
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_SEED) ? r_seed : '0;
    assign busy   = 1'b0;

    assign oct_vld[0] = r_in_vld;
    assign oct_x[0]   = r_in_x;
    assign oct_y[0]   = r_in_y;
    assign oct_sum[0] = '0;

    for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
        vnf_octave #(.OCT_IDX(o)) u_octave (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_seed  (r_seed),
            .i_valid (oct_vld[o]),
            .i_x     (oct_x[o]),
            .i_y     (oct_y[o]),
            .i_sum   (oct_sum[o]),
            .o_valid (oct_vld[o+1]),
            .o_x     (oct_x[o+1]),
            .o_y     (oct_y[o+1]),
            .o_sum   (oct_sum[o+1])
        );
    end

    vnf_div #(.OCTAVES(OCTAVES)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (oct_vld[OCTAVES]),
        .i_sum   (oct_sum[OCTAVES]),
        .o_valid (o_noise_valid),
        .o_value (o_noise_value)
    );

    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_noise_valid |-> $past(start && !busy, LATENCY))
        else $error("Result without a matching sample.");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_noise_valid |-> (o_noise_value >= -18'sd65536 && o_noise_value <= 18'sd65536))
        else $error("Noise value out of range.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_noise_valid)
        else $error("Result strobe after reset.");

endmodule
